@@ rtl/ipbg_pkg.sv @@
// Package for the IR ID pulse-burst generator: register indexes, reset values,
// configuration and state record types. No dependencies.
package ipbg_pkg;

    localparam int unsigned DurW   = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned IdW    = 8;
    localparam int unsigned PulseW = 10;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [DurW-1:0] OnDurReset   = 16'd50;
    localparam logic [DurW-1:0] OffDurReset  = 16'd100;
    localparam logic [DurW-1:0] BurstGapReset = 16'd500;

    // Largest burst length: three pulses for each step of the widest ID.
    localparam logic [PulseW-1:0] MaxPulses = 10'd765;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ON_DURATION  = 2'd0,
        REG_OFF_DURATION = 2'd1,
        REG_BURST_GAP    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DurW-1:0] on_duration;
        logic [DurW-1:0] off_duration;
        logic [DurW-1:0] burst_gap;
    } cfg_t;

    typedef struct packed {
        logic              active;
        logic              carrier_level;
        logic [PulseW-1:0] pulses_sent;
        logic [DurW-1:0]   phase_length;
        logic [TimeW-1:0]  last_change_time;
    } gen_state_t;

endpackage

@@ rtl/ir_id_pulse_burst_generator_core.sv @@
// An accepted beat passes the input register, then the result register on m_tdata.
// Throughput: one beat per cycle unless m_tready stalls; the generator state
// updates in the same cycle a beat leaves the input register, so the next beat
// sees it at once. The two registers decouple the two stream sides.
// Reset (aresetn low, synchronous): both channels empty, burst idle, carrier
// off, counters and last change time zero, registers back to 50/100/500 ms.
//
// Top level of the IR ID pulse-burst generator. Depends on ipbg_pkg and
// ipbg_step.
module ir_id_pulse_burst_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [ipbg_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [ipbg_pkg::DurW-1:0]    cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] now_ms, [39:32] sender_id
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] carrier_on, [7:1] zero
    output logic        m_tlast    // burst_done: last beat of a finished burst
);
    import ipbg_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // input stage
    logic             in_valid_reg;
    logic [TimeW-1:0] in_now_reg;
    logic [IdW-1:0]   in_id_reg;

    // generator state
    gen_state_t state_reg;
    gen_state_t state_next;

    // result stage
    logic       out_valid_reg;
    logic       out_carrier_reg;
    logic       out_done_reg;
    logic       step_carrier;
    logic       step_done;

    logic       fire;

    // Advance an item when the result register is free or draining this cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new beat whenever the input register is empty or moves on.
    assign s_tready = !in_valid_reg || fire;

    // Configuration writes; out-of-range indexes drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_duration  <= OnDurReset;
            cfg_reg.off_duration <= OffDurReset;
            cfg_reg.burst_gap    <= BurstGapReset;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ON_DURATION:  cfg_reg.on_duration  <= cfg_wdata;
                REG_OFF_DURATION: cfg_reg.off_duration <= cfg_wdata;
                REG_BURST_GAP:    cfg_reg.burst_gap    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Input register: capture a beat, hold it until processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[TimeW-1:0];
            in_id_reg  <= s_tdata[TimeW+IdW-1:TimeW];
        end
    end

    ipbg_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .now_ms     (in_now_reg),
        .sender_id  (in_id_reg),
        .nxt        (state_next),
        .carrier_on (step_carrier),
        .burst_done (step_done)
    );

    // Generator state commits only when the item moves to the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: load on fire, drop once the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_carrier_reg <= step_carrier;
            out_done_reg    <= step_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_carrier_reg};
    assign m_tlast  = out_done_reg;

    // A finished burst always leaves the carrier off.
    a_done_carrier_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> !out_carrier_reg)
        else $error("burst_done with carrier on");

    // Idle generator has no carrier and no pulse count.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.active |-> (!state_reg.carrier_level && state_reg.pulses_sent == '0))
        else $error("idle generator holds stale burst state");

    // Pulse count never passes the longest burst.
    a_pulse_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pulses_sent <= MaxPulses)
        else $error("pulse count out of range");

    // A zero ID leaves the state untouched.
    a_zero_id_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_id_reg == '0) |=> $stable(state_reg))
        else $error("state changed on zero sender ID");

    // The result carries the committed carrier level.
    a_carrier_match: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (out_carrier_reg == state_reg.carrier_level))
        else $error("result carrier differs from state");

endmodule

@@ rtl/ipbg_step.sv @@
// Next-state logic for one service call of the pulse-burst generator.
// Depends on ipbg_pkg.
module ipbg_step (
    input  ipbg_pkg::cfg_t              cfg,
    input  ipbg_pkg::gen_state_t        cur,
    input  logic [ipbg_pkg::TimeW-1:0]  now_ms,
    input  logic [ipbg_pkg::IdW-1:0]    sender_id,
    output ipbg_pkg::gen_state_t        nxt,
    output logic                        carrier_on,
    output logic                        burst_done
);
    import ipbg_pkg::*;

    logic [TimeW-1:0]  due;
    logic [TimeW-1:0]  idle_end;
    logic [PulseW-1:0] burst_len;
    logic              due_hit;
    logic              start_hit;

    assign due       = cur.last_change_time + {{(TimeW-DurW){1'b0}}, cur.phase_length};
    assign idle_end  = cur.last_change_time + {{(TimeW-DurW){1'b0}}, cfg.burst_gap};
    // 3 * id as id + 2 * id
    assign burst_len = {{(PulseW-IdW){1'b0}}, sender_id}
                     + {{(PulseW-IdW-1){1'b0}}, sender_id, 1'b0};
    assign due_hit   = (sender_id != '0) && cur.active && (now_ms >= due);
    assign start_hit = (sender_id != '0) && !cur.active && (now_ms > idle_end);

    always_comb begin
        nxt        = cur;
        burst_done = 1'b0;
        if (due_hit) begin
            if (cur.pulses_sent >= burst_len) begin
                // end of burst; keep last change time so the gap counts from it
                nxt.active        = 1'b0;
                nxt.carrier_level = 1'b0;
                nxt.pulses_sent   = '0;
                nxt.phase_length  = cfg.burst_gap;
                burst_done        = 1'b1;
            end else begin
                // on phase is tested first when both durations match
                priority if (cur.phase_length == cfg.on_duration) begin
                    nxt.carrier_level = 1'b0;
                    nxt.phase_length  = cfg.off_duration;
                    nxt.pulses_sent   = cur.pulses_sent + 1'b1;
                end else if (cur.phase_length == cfg.off_duration) begin
                    nxt.carrier_level = 1'b1;
                    nxt.phase_length  = cfg.on_duration;
                end else begin
                    // durations rewritten mid-burst: hold level and phase
                    nxt.carrier_level = cur.carrier_level;
                end
                nxt.last_change_time = now_ms;
            end
        end else if (start_hit) begin
            nxt.active           = 1'b1;
            nxt.carrier_level    = 1'b1;
            nxt.phase_length     = cfg.on_duration;
            nxt.pulses_sent      = '0;
            nxt.last_change_time = now_ms;
        end
        carrier_on = nxt.carrier_level;
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for ir_id_pulse_burst_generator_core: a scoreboard class
// predicts carrier level and burst completion per time tick; plain tasks drive the streams.
// Depends on ipbg_pkg and the generator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipbg_pkg::*;

    // Three carrier pulses are sent for every unit of the sender ID.
    localparam int PulsesPerId = 3;
    // Index past the last register: the block must ignore writes to it.
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
    localparam int RandomTicks = 150;
    localparam int Chunks = 12;

    typedef struct packed {
        logic burst_done;
        logic carrier_on;
    } tick_result_t;

    // Predicts the generator's response to each tick and holds the results still owed.
    class burst_scoreboard;
        cfg_t         regs;
        gen_state_t   gen;
        tick_result_t owed_results[$];
        int           errors;

        function new();
            regs.on_duration  = OnDurReset;
            regs.off_duration = OffDurReset;
            regs.burst_gap    = BurstGapReset;
            gen    = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] value);
            case (idx)
                REG_ON_DURATION:  regs.on_duration  = value;
                REG_OFF_DURATION: regs.off_duration = value;
                REG_BURST_GAP:    regs.burst_gap    = value;
                default: ;
            endcase
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction

        // Advance the burst state for one accepted tick and queue its result.
        function void note_tick(logic [TimeW-1:0] now_ms, logic [IdW-1:0] sender_id);
            logic [TimeW-1:0] due_ms;
            logic [TimeW-1:0] idle_end_ms;
            tick_result_t     res;
            res.burst_done = 1'b0;
            if (sender_id != '0) begin
                due_ms      = gen.last_change_time + {16'd0, gen.phase_length};
                idle_end_ms = gen.last_change_time + {16'd0, regs.burst_gap};
                if (gen.active && now_ms >= due_ms) begin
                    if (int'(gen.pulses_sent) >= int'(sender_id) * PulsesPerId) begin
                        gen.active        = 1'b0;
                        gen.carrier_level = 1'b0;
                        gen.pulses_sent   = '0;
                        gen.phase_length  = regs.burst_gap;
                        res.burst_done    = 1'b1;
                    end else begin
                        // The on-phase test wins when on and off times are equal.
                        if (gen.phase_length == regs.on_duration) begin
                            gen.carrier_level = 1'b0;
                            gen.phase_length  = regs.off_duration;
                            gen.pulses_sent   = gen.pulses_sent + 10'd1;
                        end else if (gen.phase_length == regs.off_duration) begin
                            gen.carrier_level = 1'b1;
                            gen.phase_length  = regs.on_duration;
                        end
                        gen.last_change_time = now_ms;
                    end
                end else if (!gen.active && now_ms > idle_end_ms) begin
                    gen.active           = 1'b1;
                    gen.carrier_level    = 1'b1;
                    gen.phase_length     = regs.on_duration;
                    gen.pulses_sent      = '0;
                    gen.last_change_time = now_ms;
                end
            end
            res.carrier_on = gen.carrier_level;
            owed_results.push_back(res);
        endfunction

        function void check_beat(logic [7:0] data, logic last);
            tick_result_t want;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat %02h/%0b arrived with no tick outstanding",
                             $realtime, data, last);
                return;
            end
            want = owed_results.pop_front();
            if (data[0] !== want.carrier_on || last !== want.burst_done
                    || data[7:1] !== 7'd0) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: tick result error: carrier_on exp %0b got %0b, ",
                              "burst_done exp %0b got %0b, pad got %02h"},
                             $realtime, want.carrier_on, data[0], want.burst_done, last,
                             data[7:1]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [DurW-1:0]      cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // [31:0] now_ms, [39:32] sender_id
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [0] carrier_on, [7:1] zero
    logic                 m_tlast;          // burst_done

    burst_scoreboard sb;

    // Idle percentages per side, changed by the stimulus between chunks.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    // Request for a long receiver hold-off; the receiver process takes it over.
    int          rx_hold_req  = 0;

    // Time base of the stimulus and the ID currently being sent.
    logic [TimeW-1:0] clock_ms = '0;
    logic [IdW-1:0]   cur_id   = 8'd1;

    ir_id_pulse_burst_generator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard limit: far beyond the slowest correct run.
    initial begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: stall at random, or hold off completely for a requested stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Check every result beat against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tlast);
    end

    // Offer one tick beat, idling first at random; predict it once accepted.
    // Leave tvalid high so a following tick goes out back to back.
    task automatic send_tick(input logic [TimeW-1:0] now_ms, input logic [IdW-1:0] id);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id, now_ms};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(now_ms, id);
    endtask

    // Drop tvalid and wait until every owed result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_count() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers plus the unused index, one per cycle.
    task automatic program_regs(input logic [DurW-1:0] on_ms, input logic [DurW-1:0] off_ms,
                                input logic [DurW-1:0] gap_ms);
        logic [DurW-1:0] junk;
        junk = DurW'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ON_DURATION;
        cfg_wdata <= on_ms;
        @(posedge aclk);
        cfg_index <= REG_OFF_DURATION;
        cfg_wdata <= off_ms;
        @(posedge aclk);
        cfg_index <= REG_BURST_GAP;
        cfg_wdata <= gap_ms;
        @(posedge aclk);
        cfg_index <= RegUnused;
        cfg_wdata <= junk;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(REG_ON_DURATION, on_ms);
        sb.write_reg(REG_OFF_DURATION, off_ms);
        sb.write_reg(REG_BURST_GAP, gap_ms);
        sb.write_reg(RegUnused, junk);
    endtask

    // Mostly a steadily advancing clock with a fixed ID, so bursts start, pulse and
    // finish; mixed in are idle ticks (ID zero), time jumps (backward and across
    // the wrap) and ID changes in the middle of a burst.
    task automatic run_chunk(input int n_ticks, input int unsigned step_max);
        int counted;
        int unsigned roll;
        counted = 0;
        while (counted < n_ticks) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                send_tick($urandom, 8'd0);
            end else begin
                if (roll < 10)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(step_max);
                if (roll >= 10 && roll < 13)
                    cur_id = ($urandom_range(49) == 0) ? 8'($urandom_range(255, 1))
                                                       : 8'($urandom_range(3, 1));
                send_tick(clock_ms, cur_id);
                counted++;
            end
        end
    endtask

    // Directed ticks under the reset timing (50 on, 100 off, 500 gap): idle IDs at
    // both time extremes, one full burst to its done beat, a restart with ID 255,
    // alternating bit patterns, and the due time wrapping past 2^32.
    logic [TimeW-1:0] dir_time [21] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'd100, 32'd501, 32'd551, 32'd651, 32'd700,
        32'd701, 32'd801, 32'd851, 32'd951, 32'd1000, 32'd1352, 32'd1402, 32'd1502,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0063,
        32'h0000_0200
    };
    logic [IdW-1:0] dir_id [21] = '{
        8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd255, 8'd255, 8'd0, 8'h55, 8'hAA, 8'h80, 8'd1, 8'd1, 8'd1
    };

    initial begin
        logic [DurW-1:0] on_ms, off_ms, gap_ms;
        int unsigned     longest;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 21; i++)
            send_tick(dir_time[i], dir_id[i]);
        // Closes the directed burst: its due time has passed.
        send_tick(32'h0000_0300, 8'd1);
        clock_ms = 32'h0000_0300;
        drain();

        for (int k = 0; k < Chunks; k++) begin
            case (k % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            // Registers change here while a burst may still be running, which
            // leaves the phase matching neither time on some chunks.
            case (k)
                0: begin on_ms = 16'd50;    off_ms = 16'd100;   gap_ms = 16'd500;   end
                1: begin on_ms = 16'd3;     off_ms = 16'd5;     gap_ms = 16'd10;    end
                2: begin on_ms = 16'd4;     off_ms = 16'd4;     gap_ms = 16'd6;     end
                3: begin on_ms = 16'd0;     off_ms = 16'd0;     gap_ms = 16'd0;     end
                4: begin on_ms = 16'd8;     off_ms = 16'd12;    gap_ms = 16'd20;    end
                5: begin on_ms = 16'hFFFF;  off_ms = 16'hFFFF;  gap_ms = 16'hFFFF;  end
                6: begin on_ms = 16'd0;     off_ms = 16'd7;     gap_ms = 16'd0;     end
                7: begin on_ms = 16'hFFFF;  off_ms = 16'd1;     gap_ms = 16'd2;     end
                default: begin
                    on_ms  = 16'($urandom_range(24));
                    off_ms = 16'($urandom_range(24));
                    gap_ms = 16'($urandom_range(30));
                end
            endcase
            program_regs(on_ms, off_ms, gap_ms);

            longest = on_ms;
            if (off_ms > longest) longest = off_ms;
            if (gap_ms > longest) longest = gap_ms;

            // Back-pressure: hold the receiver off while ticks keep coming, so the
            // pipeline fills and s_tready drops.
            if (k == 4)
                rx_hold_req = 400;

            run_chunk(RandomTicks, longest / 3 + 2);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.owed_count() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
